// ===== design/rfl_pkg.sv =====
// ----------------------------------------------------------------------------
// Radiotap field locator package
// Item types, result codes, the field size/alignment table and the
// command/status bundles shared by the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package rfl_pkg;

  // Number of entries in the known field table (presence bits 0 to 21).
  localparam int TABLE_LEN = 22;
  // Presence word counter width, wide enough for the largest word limit.
  localparam int WORDS_W   = 4;
  // Running offset width. The start offset is at most 64 and the table
  // holds well under 100 bytes of fields, so 9 bits never overflow.
  localparam int OFF_W     = 9;
  // Header end is 4 plus a 16-bit length.
  localparam int END_W     = 17;
  localparam int IDX_W     = 5;

  // Result status codes.
  localparam logic [1:0] ST_FIELD     = 2'd0;
  localparam logic [1:0] ST_EMPTY     = 2'd1;
  localparam logic [1:0] ST_MALFORMED = 2'd2;

  typedef struct packed {
    logic [31:0] present_word;
    logic [15:0] header_length;
  } word_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [4:0]  field_index;
    logic [15:0] field_offset;
    logic [3:0]  field_size;
    logic        last;
  } result_item_t;

  typedef struct packed {
    logic [3:0] size;
    logic [3:0] align;
  } field_meta_t;

  // Controller to datapath.
  typedef struct packed {
    logic take;  // a presence word is accepted this cycle
    logic step;  // produce one result into the output register
  } rfl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic ends_header;  // the offered word closes the header
    logic slot_free;    // output register can take a new result
    logic step_last;    // the result produced by a step is the final one
  } rfl_status_t;

  // Size and alignment of each known radiotap field.
  function automatic field_meta_t field_meta(input logic [IDX_W-1:0] idx);
    field_meta_t m;
    case (idx)
      5'd0:    m = '{size: 4'd8,  align: 4'd8};
      5'd3:    m = '{size: 4'd4,  align: 4'd2};
      5'd4,
      5'd7,
      5'd8,
      5'd9,
      5'd14,
      5'd15:   m = '{size: 4'd2,  align: 4'd2};
      5'd18,
      5'd20:   m = '{size: 4'd8,  align: 4'd4};
      5'd19:   m = '{size: 4'd3,  align: 4'd1};
      5'd21:   m = '{size: 4'd12, align: 4'd2};
      default: m = '{size: 4'd1,  align: 4'd1};
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

// ===== design/rfl_ctrl.sv =====
// ----------------------------------------------------------------------------
// Radiotap field locator controller
// Two-state sequencer: takes presence words while idle, then steps the
// datapath through the field walk one result at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module rfl_ctrl
  import rfl_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  word_valid,
  output logic       word_ready,
  input  wire rfl_status_t sts,
  output rfl_cmd_t   cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_RUN  = 1'b1;

  logic state;
  logic state_next;

  always_comb begin
    word_ready = (state == S_IDLE);
    cmd.take   = word_valid && (state == S_IDLE);
    cmd.step   = (state == S_RUN) && sts.slot_free;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd.take && sts.ends_header) begin
          state_next = S_RUN;
        end
      end
      S_RUN: begin
        if (cmd.step && sts.step_last) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/rfl_datapath.sv =====
// ----------------------------------------------------------------------------
// Radiotap field locator datapath
// Word counter, saved first bitmap and length, field walk registers and the
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rfl_datapath
  import rfl_pkg::*;
#(
  parameter int MAX_WORDS  = 8,
  parameter int NUM_FIELDS = 22
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire rfl_cmd_t cmd,
  output rfl_status_t sts,
  input  wire word_item_t word,
  output logic        result_valid,
  input  wire logic   result_ready,
  output result_item_t result
);

  localparam int WALK_LEN = (NUM_FIELDS < TABLE_LEN) ? NUM_FIELDS : TABLE_LEN;
  localparam logic [TABLE_LEN-1:0] WALK_MASK =
    TABLE_LEN'(((TABLE_LEN+1)'(1) << WALK_LEN) - (TABLE_LEN+1)'(1));

  logic [WORDS_W-1:0]   words_seen;
  logic [TABLE_LEN-1:0] first_bitmap;
  logic [15:0]          saved_length;
  logic [TABLE_LEN-1:0] remaining;
  logic [OFF_W-1:0]     offset;
  logic [END_W-1:0]     hdr_end;
  logic                 pend_err;

  // Word intake.
  logic [WORDS_W-1:0]   words_next;
  logic                 too_many;
  logic                 word_final;
  logic [TABLE_LEN-1:0] eff_bitmap;
  logic [15:0]          eff_length;
  logic                 short_len;

  always_comb begin
    words_next = words_seen + WORDS_W'(1);
    word_final = !word.present_word[31];
    too_many   = word.present_word[31] && (words_next >= WORDS_W'(MAX_WORDS));
    eff_bitmap = (words_seen == '0) ? word.present_word[TABLE_LEN-1:0] : first_bitmap;
    eff_length = (words_seen == '0) ? word.header_length : saved_length;
    short_len  = eff_length < 16'({words_next, 2'b00});
  end

  // One walk step: lowest remaining bit, aligned offset and overrun check.
  logic [TABLE_LEN-1:0] sel_onehot;
  logic [IDX_W-1:0]     sel_idx;
  field_meta_t          meta;
  logic [OFF_W-1:0]     align_mask;
  logic [OFF_W-1:0]     aligned;
  logic [END_W-1:0]     field_end;
  logic [TABLE_LEN-1:0] rem_after;
  result_item_t         step_res;

  always_comb begin
    sel_onehot = remaining & (~remaining + TABLE_LEN'(1));
    sel_idx    = '0;
    for (int i = TABLE_LEN - 1; i >= 0; i--) begin
      if (remaining[i]) begin
        sel_idx = IDX_W'(i);
      end
    end
    meta       = field_meta(sel_idx);
    align_mask = OFF_W'(meta.align - 4'd1);
    aligned    = (offset + align_mask) & ~align_mask;
    field_end  = END_W'(aligned) + END_W'(meta.size);
    rem_after  = remaining & ~sel_onehot;

    step_res = '{status: ST_FIELD, field_index: 5'd0, field_offset: 16'd0,
                 field_size: 4'd0, last: 1'b1};
    if (pend_err) begin
      step_res.status = ST_MALFORMED;
    end else if (remaining == '0) begin
      step_res.status = ST_EMPTY;
    end else if (field_end > hdr_end) begin
      step_res.status = ST_MALFORMED;
    end else begin
      step_res.field_index  = sel_idx;
      step_res.field_offset = 16'(aligned);
      step_res.field_size   = meta.size;
      step_res.last         = (rem_after == '0);
    end

    sts.ends_header = word_final || too_many;
    sts.slot_free   = !result_valid || result_ready;
    sts.step_last   = step_res.last;
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      words_seen   <= '0;
      result_valid <= 1'b0;
    end else begin
      if (cmd.take) begin
        words_seen <= sts.ends_header ? '0 : words_next;
      end
      if (cmd.step) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      if (words_seen == '0) begin
        first_bitmap <= word.present_word[TABLE_LEN-1:0];
        saved_length <= word.header_length;
      end
      if (sts.ends_header) begin
        pend_err  <= too_many || short_len;
        remaining <= eff_bitmap & WALK_MASK;
        offset    <= OFF_W'({words_next, 2'b00}) + OFF_W'(4);
        hdr_end   <= END_W'(eff_length) + END_W'(4);
      end
    end
    if (cmd.step) begin
      remaining <= rem_after;
      offset    <= aligned + OFF_W'(meta.size);
      result    <= step_res;
    end
  end

  // A result that is not a located field always closes its header.
  a_nonfield_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.status != ST_FIELD) |-> result.last)
    else $error("non-field result without last");

  // Located fields come from the table and sit past the presence words.
  a_field_sane: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.status == ST_FIELD) |->
      (result.field_index < 5'(TABLE_LEN)) && (result.field_size != 4'd0) &&
      (result.field_offset >= 16'd8))
    else $error("located field out of range");

  // The word counter wraps back before it reaches the limit.
  a_words_bound: assert property (@(posedge clk) disable iff (rst)
    words_seen < WORDS_W'(MAX_WORDS))
    else $error("presence word count beyond limit");

  // A new result is only written over a slot that is empty or being drained.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> $stable(result))
    else $error("pending result overwritten");

endmodule

`default_nettype wire

// ===== design/radiotap_field_locator_unit.sv =====
// ----------------------------------------------------------------------------
// Radiotap field locator
// Takes the presence words of a radiotap header and reports the aligned
// offset and size of every known field flagged in the first word.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake                   Payload
//   -------   -------------------------   -------------------------------------
//   word      word_valid / word_ready     word_item_t: present_word, header_length
//   result    result_valid / result_ready result_item_t: status, field_index,
//                                         field_offset, field_size, last
//
// A presence word with bit 31 set, below the word limit, is taken and
// gives no result. A word that closes the header is taken, after which
// the controller walks the flagged fields, producing one result per cycle
// while the consumer keeps up, so a header closing with k results holds
// off the next word until its final result is produced.
// The pace is set by the single field-walk step in the datapath: one
// priority pick, one alignment and one overrun compare per result.
// Reset is synchronous and active high; it empties the output register and
// clears the word count and the sequencer. A stalled consumer simply holds
// the walk, and no word is accepted until the final result is produced.
//
// ----------------------------------------------------------------------------
`default_nettype none

module radiotap_field_locator_unit
  import rfl_pkg::*;
#(
  parameter int MAX_WORDS  = 8,
  parameter int NUM_FIELDS = 22
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   word_valid,
  output logic        word_ready,
  input  wire word_item_t word,
  output logic        result_valid,
  input  wire logic   result_ready,
  output result_item_t result
);

  // Commands from the sequencer and status back from the datapath.
  rfl_cmd_t    cmd;
  rfl_status_t sts;

  rfl_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .word_valid (word_valid),
    .word_ready (word_ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // The datapath owns all item storage, including the output register, so
  // a finished result waits there while the walk is paused.
  rfl_datapath #(
    .MAX_WORDS  (MAX_WORDS),
    .NUM_FIELDS (NUM_FIELDS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .word         (word),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

`default_nettype wire
